FILE: src/rdfp_pkg.sv
// Shared types and constants for the remote drive frame parser.
`default_nettype none

package rdfp_pkg;

  localparam logic [7:0] HEAD_0    = 8'hF1;
  localparam logic [7:0] HEAD_1    = 8'hE1;
  localparam logic [7:0] TAIL_BYTE = 8'hF2;
  localparam logic [7:0] FLAG_EXIT = 8'h01;

  localparam int unsigned CENTER_W = 15;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'b1;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_STOP  = 1'b1
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] motor_drive;
    logic [15:0] servo_drive;
    logic        exit_manual;
  } result_t;

endpackage

`default_nettype wire

FILE: src/rdfp_in_reg.sv
// Input register holding one accepted beat until the parse stage takes it.
`default_nettype none

module rdfp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rdfp_pkg::item_t in_item,
  output logic               held,
  output rdfp_pkg::item_t    item,
  input  wire logic          take
);
  import rdfp_pkg::*;

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: src/rdfp_engine.sv
// Frame parser state, watchdog counter, configuration registers and result logic.
`default_nettype none

module rdfp_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rdfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rdfp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          item_valid,
  input  wire rdfp_pkg::item_t               item,
  input  wire logic                          slot_free,
  output logic                               take,
  output logic                               res_valid,
  output rdfp_pkg::result_t                  res
);
  import rdfp_pkg::*;

  logic [CENTER_W-1:0] servo_center;
  logic [LIMIT_W-1:0]  timeout_limit;
  logic [2:0]          pos;
  logic [2:0]          pos_next;
  logic [15:0]         idle_ticks;
  logic [39:0]         body;
  logic                is_byte;
  logic                hdr_bad;
  logic                last;
  logic                frame_ok;
  logic                stop;
  logic                exit_req;

  assign take     = item_valid && slot_free;
  assign is_byte  = item.op == OP_BYTE;
  assign hdr_bad  = (pos == 3'd0 && item.rx_byte != HEAD_0) ||
                    (pos == 3'd1 && item.rx_byte != HEAD_1);
  assign last     = pos == 3'd7;
  assign frame_ok = last && item.rx_byte == TAIL_BYTE;
  assign exit_req = body[7:0] == FLAG_EXIT;
  assign stop     = idle_ticks > timeout_limit;

  always_comb begin
    pos_next = (hdr_bad || last) ? 3'd0 : pos + 3'd1;
    res_valid = is_byte ? frame_ok : stop;
    if (is_byte) begin
      res.kind        = KIND_FRAME;
      res.motor_drive = body[39:24];
      res.servo_drive = body[23:8] + {1'b0, servo_center};
      res.exit_manual = exit_req;
    end else begin
      res.kind        = KIND_STOP;
      res.motor_drive = 16'd0;
      res.servo_drive = {1'b0, servo_center};
      res.exit_manual = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_center  <= '0;
      timeout_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVO_CENTER:  servo_center  <= cfg_data[CENTER_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 3'd0;
      idle_ticks <= 16'd0;
    end else if (take) begin
      if (is_byte) begin
        pos <= pos_next;
        // An exit request leaves the watchdog running.
        if (frame_ok && !exit_req) begin
          idle_ticks <= 16'd0;
        end
      end else if (idle_ticks != 16'hFFFF) begin
        idle_ticks <= idle_ticks + 16'd1;
      end
    end
  end

  // Payload bytes two through six shift in; the tail compares the live byte.
  always_ff @(posedge clk) begin
    if (take && is_byte && pos >= 3'd2 && !last) begin
      body <= {body[31:0], item.rx_byte};
    end
  end

`ifndef SYNTH
  a_frame_at_tail: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == KIND_FRAME |-> pos == 3'd7)
    else $error("frame result away from the tail position");

  a_good_frame_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_byte && frame_ok && !exit_req |=> idle_ticks == 16'd0)
    else $error("good frame did not clear the watchdog");

  a_stop_past_limit: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == KIND_STOP |-> idle_ticks > timeout_limit)
    else $error("stop issued below the limit");

  a_restart_after_frame: assert property (@(posedge clk) disable iff (rst)
    take && is_byte && last |=> pos == 3'd0)
    else $error("position did not restart after the eighth byte");
`endif

endmodule

`default_nettype wire

FILE: src/rdfp_out_reg.sv
// Result register that holds a beat until the consumer takes it.
`default_nettype none

module rdfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire rdfp_pkg::result_t res,
  output logic                   slot_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rdfp_pkg::result_t      out_res
);
  import rdfp_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

FILE: src/remote_drive_frame_parser_core.sv
// Top level of the remote drive frame parser.
//
//   Channel  Signals                                          Direction
//   in       in_valid, in_ready, op, rx_byte                  into the block
//   out      out_valid, out_ready, kind, motor_drive,
//            servo_drive, exit_manual                         out of the block
//   cfg      cfg_we, cfg_index, cfg_data                      into the block
//
// One beat is accepted per cycle while in_ready is high; the result is registered.
// The input register feeds a single parse stage that writes the result register.
// While out_ready is low with a result pending, the input register fills and then stalls.
// Synchronous reset clears the frame position, the watchdog count and the hold flags of both registers.
`default_nettype none

module remote_drive_frame_parser_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               kind,
  output logic signed [15:0]                 motor_drive,
  output logic signed [15:0]                 servo_drive,
  output logic                               exit_manual,
  input  wire logic                          cfg_we,
  input  wire logic [rdfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rdfp_pkg::CFG_W-1:0]     cfg_data
);
  import rdfp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    held;
  logic    take;
  logic    slot_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.op      = op_e'(op);
  assign in_item.rx_byte = rx_byte;

  rdfp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .held     (held),
    .item     (item),
    .take     (take)
  );

  rdfp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (held),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rdfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign motor_drive = out_res.motor_drive;
  assign servo_drive = out_res.servo_drive;
  assign exit_manual = out_res.exit_manual;

endmodule

`default_nettype wire
